// ===== hdl/mfp_pkg.sv =====
// types, constants and helper functions for the midi file track event parser
// no dependencies

package mfp_pkg;

  localparam logic [7:0]  ST_SYSEX     = 8'hF0;
  localparam logic [7:0]  ST_ESCAPE    = 8'hF7;
  localparam logic [7:0]  ST_META      = 8'hFF;
  localparam logic [7:0]  ST_SONG_POS  = 8'hF2;
  localparam logic [7:0]  ST_TIME_CODE = 8'hF1;
  localparam logic [7:0]  ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0]  META_SEQUENCE = 8'h00;
  localparam logic [7:0]  META_TEXT_LO = 8'h01;
  localparam logic [7:0]  META_TEXT_HI = 8'h09;
  localparam logic [7:0]  META_EOT     = 8'h2F;
  localparam logic [7:0]  META_SET_TEMPO = 8'h51;
  localparam logic [7:0]  META_TIME_SIG = 8'h58;
  localparam logic [7:0]  META_KEY_SIG = 8'h59;
  localparam logic [3:0]  HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0]  HI_NOTE_ON   = 4'h9;
  localparam logic [3:0]  HI_POLY_AT   = 4'hA;
  localparam logic [3:0]  HI_CONTROL   = 4'hB;
  localparam logic [3:0]  HI_PROGRAM   = 4'hC;
  localparam logic [3:0]  HI_CHAN_AT   = 4'hD;
  localparam logic [3:0]  HI_BEND      = 4'hE;
  localparam logic [23:0] TEMPO_RESET  = 24'd500000;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_PARAMS,
    PH_META,
    PH_LENGTH,
    PH_DATA,
    PH_PAYLOAD
  } mfp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } mfp_in_t;

  typedef struct packed {
    logic        is_payload;
    logic [27:0] delta_time;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [7:0]  meta_type;
    logic [7:0]  param_count;
    logic [31:0] params;
    logic        is_text;
    logic        last_of_event;
    logic [23:0] tempo;
    logic [6:0]  patch;
    logic        end_of_track;
  } mfp_out_t;

  typedef struct packed {
    mfp_phase_t  phase;
    logic [27:0] delta;
    logic [1:0]  vcnt;
    logic [27:0] len;
    logic [7:0]  status;
    logic [7:0]  run_status;
    logic [7:0]  meta;
    logic [31:0] params;
    logic [7:0]  bytes_rem;
    logic [23:0] tempo;
    logic [6:0]  patch;
    logic [7:0]  idx;
  } mfp_state_t;

  localparam mfp_state_t STATE_RESET = '{
    phase:      PH_DELTA,
    delta:      28'd0,
    vcnt:       2'd0,
    len:        28'd0,
    status:     8'd0,
    run_status: 8'd0,
    meta:       8'd0,
    params:     32'd0,
    bytes_rem:  8'd0,
    tempo:      TEMPO_RESET,
    patch:      7'd0,
    idx:        8'd0
  };

  function automatic logic [7:0] fixed_count(input logic [7:0] s);
    logic [7:0] n;
    n = 8'd0;
    case (s[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_BEND: n = 8'd2;
      HI_PROGRAM, HI_CHAN_AT: n = 8'd1;
      default: begin
        if (s == ST_TIME_CODE || s == ST_SONG_SEL) n = 8'd1;
        else if (s == ST_SONG_POS) n = 8'd2;
      end
    endcase
    return n;
  endfunction

  function automatic logic is_text_meta(input logic [7:0] s, input logic [7:0] m);
    return s == ST_META && m >= META_TEXT_LO && m <= META_TEXT_HI;
  endfunction

  function automatic logic is_fixed_meta(input logic [7:0] s, input logic [7:0] m);
    return s == ST_META && (m == META_SEQUENCE || m == META_EOT || m == META_SET_TEMPO ||
                            m == META_TIME_SIG || m == META_KEY_SIG);
  endfunction

endpackage

// ===== hdl/mfp_step.sv =====
// per-byte parse step: current state and one track byte to next state and result
// depends on mfp_pkg

module mfp_step import mfp_pkg::*; #(
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  mfp_state_t st,
  input  mfp_in_t    word,
  output mfp_state_t st_nxt,
  output logic       emit,
  output mfp_out_t   res
);

  localparam logic [2:0] VL_MAX = 3'(MAX_VARLEN_BYTES);

  logic [7:0]  b;
  mfp_state_t  s;
  logic        do_param;
  logic        do_finish;
  logic        e_payload;
  logic        e_last;
  logic        e_eot;
  logic [31:0] e_params;
  logic [27:0] e_delta;
  logic [7:0]  v;

  function automatic mfp_state_t start_event(input mfp_state_t x);
    mfp_state_t y;
    y = x;
    y.phase = PH_DELTA;
    y.delta = 28'd0;
    y.vcnt  = 2'd0;
    return y;
  endfunction

  function automatic mfp_state_t delta_byte(input mfp_state_t x, input logic [7:0] d);
    mfp_state_t y;
    y = x;
    y.delta = {x.delta[20:0], d[6:0]};
    if (!d[7] || ({1'b0, x.vcnt} + 3'd1) >= VL_MAX) begin
      y.vcnt  = 2'd0;
      y.phase = PH_STATUS;
    end else begin
      y.vcnt = x.vcnt + 2'd1;
    end
    return y;
  endfunction

  function automatic mfp_state_t begin_status(input mfp_state_t x, input logic [7:0] d);
    mfp_state_t y;
    y = x;
    y.status    = d;
    y.meta      = 8'd0;
    y.params    = 32'd0;
    y.idx       = 8'd0;
    y.bytes_rem = fixed_count(d);
    return y;
  endfunction

  assign b = word.data_byte;

  // next state and emit control
  always_comb begin
    s         = word.track_start ? STATE_RESET : st;
    emit      = 1'b0;
    do_param  = 1'b0;
    do_finish = 1'b0;
    e_payload = 1'b0;
    e_last    = 1'b0;
    e_eot     = 1'b0;
    e_params  = 32'd0;
    e_delta   = s.delta;
    v         = b;

    case (s.phase)
      PH_STATUS: begin
        if (b[7]) begin
          s = begin_status(s, b);
          if (b < ST_SYSEX) begin
            s.run_status = b;
            s.phase      = PH_PARAMS;
          end else begin
            s.run_status = 8'd0;
            if (b == ST_SYSEX || b == ST_ESCAPE) begin
              s.len   = 28'd0;
              s.vcnt  = 2'd0;
              s.phase = PH_LENGTH;
            end else if (b == ST_META) begin
              s.phase = PH_META;
            end else if (s.bytes_rem == 8'd0) begin
              emit    = 1'b1;
              e_last  = 1'b1;
              e_delta = s.delta;
              s       = start_event(s);
            end else begin
              s.phase = PH_PARAMS;
            end
          end
        end else if (s.run_status == 8'd0) begin
          // data byte with no running status: empty header, byte opens next delta
          s       = begin_status(s, 8'd0);
          emit    = 1'b1;
          e_last  = 1'b1;
          e_delta = s.delta;
          s       = start_event(s);
          s       = delta_byte(s, b);
        end else begin
          s        = begin_status(s, s.run_status);
          s.phase  = PH_PARAMS;
          do_param = 1'b1;
        end
      end
      PH_PARAMS: do_param = 1'b1;
      PH_META: begin
        s.meta  = b;
        s.len   = 28'd0;
        s.vcnt  = 2'd0;
        s.phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        s.len = {s.len[20:0], b[6:0]};
        if (b[7] && ({1'b0, s.vcnt} + 3'd1) < VL_MAX) begin
          s.vcnt = s.vcnt + 2'd1;
        end else begin
          s.vcnt      = 2'd0;
          s.bytes_rem = (|s.len[27:8]) ? 8'hFF : s.len[7:0];
          s.idx       = 8'd0;
          if (is_fixed_meta(s.status, s.meta)) begin
            if (s.len == 28'd0) do_finish = 1'b1;
            else s.phase = PH_DATA;
          end else if (s.len == 28'd0) begin
            emit    = 1'b1;
            e_last  = 1'b1;
            e_delta = s.delta;
            s       = start_event(s);
          end else begin
            emit    = 1'b1;
            e_delta = s.delta;
            s.phase = PH_PAYLOAD;
          end
        end
      end
      PH_DATA: begin
        if (s.idx < 8'd4) begin
          s.params = s.params | ({24'd0, b} << {s.idx[1:0], 3'b000});
        end
        if (s.idx != 8'hFF) s.idx = s.idx + 8'd1;
        s.len = s.len - 28'd1;
        if (s.len == 28'd0) do_finish = 1'b1;
      end
      PH_PAYLOAD: begin
        s.len     = s.len - 28'd1;
        emit      = 1'b1;
        e_payload = 1'b1;
        e_params  = {24'd0, b};
        e_delta   = s.delta;
        if (s.len == 28'd0) begin
          e_last = 1'b1;
          s      = start_event(s);
        end
      end
      default: s = delta_byte(s, b);
    endcase

    if (do_param) begin
      // pitch bend keeps 7 bits of the first byte, second byte shifted down
      if (s.status[7:4] == HI_BEND) begin
        v = (s.idx == 8'd0) ? {1'b0, b[6:0]} : {1'b0, b[7:1]};
      end
      if (s.idx < 8'd4) begin
        s.params = s.params | ({24'd0, v} << {s.idx[1:0], 3'b000});
      end
      s.idx = s.idx + 8'd1;
      if (s.idx >= s.bytes_rem) begin
        if (s.status[7:4] == HI_PROGRAM) s.patch = s.params[6:0];
        emit     = 1'b1;
        e_last   = 1'b1;
        e_params = s.params;
        e_delta  = s.delta;
        s        = start_event(s);
      end
    end

    if (do_finish) begin
      if (s.meta == META_SET_TEMPO) s.tempo = {s.params[7:0], s.params[15:8], s.params[23:16]};
      emit     = 1'b1;
      e_last   = 1'b1;
      e_eot    = s.meta == META_EOT;
      e_params = s.params;
      e_delta  = s.delta;
      s        = start_event(s);
    end

    st_nxt = s;
  end

  // result word
  always_comb begin
    res.is_payload    = e_payload;
    res.delta_time    = e_delta;
    res.status        = st_nxt.status;
    res.channel       = (st_nxt.status[7] && st_nxt.status < ST_SYSEX) ?
                        st_nxt.status[3:0] : 4'd0;
    res.meta_type     = (st_nxt.status == ST_META) ? st_nxt.meta : 8'd0;
    res.param_count   = st_nxt.bytes_rem;
    res.params        = e_params;
    res.is_text       = is_text_meta(st_nxt.status, st_nxt.meta);
    res.last_of_event = e_last;
    res.tempo         = st_nxt.tempo;
    res.patch         = st_nxt.patch;
    res.end_of_track  = e_eot;
  end

endmodule

// ===== hdl/midi_file_track_event_parser.sv =====
// top level of the midi file track event parser: input register, parse step, result register
// depends on mfp_pkg and mfp_step
//
//  channel   direction  word        handshake
//  in_       input      mfp_in_t    in_valid / in_stall
//  out_      output     mfp_out_t   out_valid / out_stall
//
// one track byte per cycle while in_stall is low, every byte goes through a single parse step
// a result word is registered from the parse step of the byte held in the input register
// other than streamed payload bytes, bytes that close no event or field give no result word
// rst_n is synchronous: parse state returns to delta, tempo to 500000
// in_stall rises only when a byte is held and the result register is full and stalled

module midi_file_track_event_parser import mfp_pkg::*; #(
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mfp_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output mfp_out_t out_word
);

  logic       in_vld_r;
  mfp_in_t    in_word_r;
  mfp_state_t st_r;
  mfp_state_t st_nxt;
  logic       out_vld_r;
  mfp_out_t   out_word_r;
  logic       emit;
  mfp_out_t   res;
  logic       out_free;
  logic       advance;

  mfp_step #(
    .MAX_VARLEN_BYTES(MAX_VARLEN_BYTES)
  ) u_step (
    .st    (st_r),
    .word  (in_word_r),
    .st_nxt(st_nxt),
    .emit  (emit),
    .res   (res)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/mfp_checker.sv =====
// port-level checks for the midi file track event parser, bound to the top level
// depends on mfp_pkg

module mfp_checker import mfp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input mfp_in_t  in_word,
  input logic     out_valid,
  input logic     out_stall,
  input mfp_out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_eot_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.end_of_track |->
      !out_word.is_payload && out_word.status == ST_META &&
      out_word.meta_type == META_EOT && out_word.last_of_event)
    else $error("end of track on a word that is not its header");

  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.channel != 4'd0 |->
      out_word.status[7] && out_word.status < ST_SYSEX)
    else $error("channel set on a non-channel status");

  a_payload_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_payload |->
      out_word.status == ST_SYSEX || out_word.status == ST_ESCAPE ||
      out_word.status == ST_META)
    else $error("payload word on an event that streams no payload");

endmodule

bind midi_file_track_event_parser mfp_checker u_mfp_checker (.*);
